[sv/bba_pkg.sv]
package bba_pkg;

	localparam int NUM_BLOCKS = 256;
	localparam int LOG_NB     = $clog2(NUM_BLOCKS);
	localparam int NODES      = 2 * NUM_BLOCKS - 1;
	localparam int IDX_W      = $clog2(NODES);
	localparam int VAL_W      = LOG_NB + 1;
	localparam int CNT_W      = LOG_NB + 2;
	localparam int STEP_W     = (LOG_NB > 1) ? $clog2(LOG_NB) : 1;
	localparam int BB_W       = 17;
	localparam int REQ_W      = 25;
	localparam int OFF_W      = 24;
	localparam int PBB_W      = BB_W + CNT_W - 1;
	localparam int MUL_W      = BB_W + VAL_W;

	localparam logic [BB_W-1:0] BB_MIN   = BB_W'(4);
	localparam logic [BB_W-1:0] BB_MAX   = BB_W'(65536);
	localparam logic [BB_W-1:0] BB_RESET = BB_W'(64);

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [REQ_W-1:0] request_bytes;
		logic [OFF_W-1:0] byte_offset;
	} bba_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFF_W-1:0] result_offset;
		logic [REQ_W-1:0] size_bytes;
	} bba_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ASIZE, S_AROOT, S_ADESC, S_ADCHK, S_AMUL, S_ACHK,
		S_FDIV, S_FRD, S_FCHK, S_UPSTEP, S_UPL, S_UPR
	} bba_state_t;

endpackage

[sv/buddy_block_allocator.sv]
// Buddy allocator over NUM_BLOCKS equal blocks, kept as a binary tree of the largest free
// run per node in a single-port-read memory. After reset the block sweeps the tree back to
// its initial contents with busy high. An operation is taken on start while busy is low;
// its one result beat follows with done high for one cycle and cannot be stalled, so the
// receiver must take it then. An allocate rounds the size up, reads the root, descends
// one tree level at a time to the granted node, multiplies out the offset and then updates
// the ancestors; a free or query takes log2(NUM_BLOCKS) divide steps, then climbs to the
// allocation, a free then updating each level back to the root.
module buddy_block_allocator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  bba_pkg::bba_req_t       req,
	output logic                    done,
	output bba_pkg::bba_rsp_t       result,
	input  logic                    cfg_we,
	input  logic [bba_pkg::BB_W-1:0] cfg_data
);
	import bba_pkg::*;

	// tree memory
	logic [VAL_W-1:0] mem [0:NODES-1];
	logic [VAL_W-1:0] rdata_q;
	logic [IDX_W-1:0] raddr, waddr;
	logic [VAL_W-1:0] wdata;
	logic             we;

	bba_state_t state_q, state_d;
	logic [BB_W-1:0]   bb_q;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  nsz_q, nsz_d, p_q, p_d;
	logic [PBB_W-1:0]  pbb_q, pbb_d;
	logic [LOG_NB-1:0] blk_q, blk_d, quo_q, quo_d, quo_n;
	logic [MUL_W-1:0]  prod_q, prod_d, mul_res;
	logic [VAL_W-1:0]  mul_a;
	logic [REQ_W-1:0]  rem_q, rem_d, dv;
	logic [STEP_W-1:0] bit_q, bit_d;
	logic [VAL_W-1:0]  l_q, l_d;
	logic [VAL_W:0]    lr_sum;
	logic [VAL_W-1:0]  lr_max;
	logic [OFF_W-1:0]  off_q, off_d;
	logic [REQ_W-1:0]  size_q, size_d, req_bytes_q, req_bytes_d;
	logic              is_free_q, is_free_d;
	logic              fin;
	logic [1:0]        fin_st;
	logic              done_q;
	bba_rsp_t          rsp_q, rsp_d;
	logic [IDX_W-1:0]  par;

	// memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// block size register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q <= BB_RESET;
		end else if (cfg_we) begin
			if (cfg_data < BB_MIN)
				bb_q <= BB_MIN;
			else if (cfg_data > BB_MAX)
				bb_q <= BB_MAX;
			else
				bb_q <= cfg_data;
		end
	end

	// shared arithmetic
	assign mul_a   = (state_q == S_AMUL) ? VAL_W'({1'b0, blk_q} + p_q[VAL_W-1:0])
	                                     : nsz_q[VAL_W-1:0];
	assign mul_res = MUL_W'(mul_a) * MUL_W'(bb_q);
	assign dv      = REQ_W'(bb_q) << bit_q;
	assign par     = (idx_q - IDX_W'(1)) >> 1;
	assign lr_sum  = {1'b0, l_q} + {1'b0, rdata_q};
	assign lr_max  = (l_q > rdata_q) ? l_q : rdata_q;

	always_comb begin
		quo_n = quo_q;
		quo_n[bit_q[STEP_W-1:0]] = (rem_q >= dv);
	end

	// sequencer: next state and datapath updates
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		nsz_d       = nsz_q;
		p_d         = p_q;
		pbb_d       = pbb_q;
		blk_d       = blk_q;
		quo_d       = quo_q;
		prod_d      = prod_q;
		rem_d       = rem_q;
		bit_d       = bit_q;
		l_d         = l_q;
		off_d       = off_q;
		size_d      = size_q;
		req_bytes_d = req_bytes_q;
		is_free_d   = is_free_q;
		raddr       = idx_q;
		waddr       = idx_q;
		wdata       = '0;
		we          = 1'b0;
		fin         = 1'b0;
		fin_st      = ST_OK;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				if (((idx_q + IDX_W'(1)) & idx_q) == '0) begin
					nsz_d = nsz_q >> 1;
					wdata = VAL_W'(nsz_q >> 1);
				end else begin
					wdata = nsz_q[VAL_W-1:0];
				end
				idx_d = idx_q + IDX_W'(1);
				if (idx_q == IDX_W'(NODES - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					req_bytes_d = req.request_bytes;
					off_d       = '0;
					is_free_d   = (req.action == ACT_FREE);
					case (req.action)
						ACT_ALLOC: begin
							if (req.request_bytes == '0) begin
								fin = 1'b1; fin_st = ST_BAD;
							end else begin
								p_d     = CNT_W'(1);
								pbb_d   = PBB_W'(bb_q);
								state_d = S_ASIZE;
							end
						end
						ACT_FREE, ACT_QUERY: begin
							if (REQ_W'(req.byte_offset) >= (REQ_W'(bb_q) << LOG_NB)) begin
								fin = 1'b1; fin_st = ST_BAD;
							end else begin
								rem_d   = REQ_W'(req.byte_offset);
								quo_d   = '0;
								bit_d   = STEP_W'(LOG_NB - 1);
								state_d = S_FDIV;
							end
						end
						default: begin
							fin = 1'b1; fin_st = ST_BAD;
						end
					endcase
				end
			end
			// round the request up to a power-of-two block count
			S_ASIZE: begin
				if (pbb_q < PBB_W'(req_bytes_q) && p_q <= CNT_W'(NUM_BLOCKS)) begin
					p_d   = p_q << 1;
					pbb_d = pbb_q << 1;
				end else if (p_q > CNT_W'(NUM_BLOCKS)) begin
					fin = 1'b1; fin_st = ST_FAIL; state_d = S_IDLE;
				end else begin
					raddr   = '0;
					state_d = S_AROOT;
				end
			end
			S_AROOT: begin
				if (CNT_W'(rdata_q) < p_q) begin
					fin = 1'b1; fin_st = ST_FAIL; state_d = S_IDLE;
				end else begin
					idx_d   = '0;
					nsz_d   = CNT_W'(NUM_BLOCKS);
					blk_d   = '0;
					state_d = S_ADESC;
				end
			end
			// descend, preferring the left child
			S_ADESC: begin
				if (nsz_q == p_q) begin
					state_d = S_AMUL;
				end else begin
					raddr   = (idx_q << 1) + IDX_W'(1);
					state_d = S_ADCHK;
				end
			end
			S_ADCHK: begin
				if (CNT_W'(rdata_q) >= p_q) begin
					idx_d = (idx_q << 1) + IDX_W'(1);
				end else begin
					idx_d = (idx_q << 1) + IDX_W'(2);
					blk_d = blk_q + LOG_NB'(nsz_q >> 1);
				end
				nsz_d   = nsz_q >> 1;
				state_d = S_ADESC;
			end
			S_AMUL: begin
				prod_d  = mul_res;
				state_d = S_ACHK;
			end
			// reject grants past the address space, else mark taken
			S_ACHK: begin
				if (prod_q > MUL_W'(25'h1000000)) begin
					fin = 1'b1; fin_st = ST_FAIL; state_d = S_IDLE;
				end else begin
					off_d  = OFF_W'(prod_q - MUL_W'(pbb_q));
					size_d = REQ_W'(pbb_q);
					we     = 1'b1;
					wdata  = '0;
					if (idx_q == '0) begin
						fin = 1'b1; state_d = S_IDLE;
					end else begin
						state_d = S_UPSTEP;
					end
				end
			end
			// restoring divide of offset by block size, one bit a cycle
			S_FDIV: begin
				if (rem_q >= dv)
					rem_d = rem_q - dv;
				quo_d = quo_n;
				if (bit_q == '0) begin
					idx_d   = IDX_W'(quo_n) + IDX_W'(NUM_BLOCKS - 1);
					nsz_d   = CNT_W'(1);
					state_d = S_FRD;
				end else begin
					bit_d = bit_q - STEP_W'(1);
				end
			end
			S_FRD: begin
				state_d = S_FCHK;
			end
			// climb to the first taken node
			S_FCHK: begin
				if (rdata_q == '0) begin
					size_d = REQ_W'(mul_res);
					if (!is_free_q) begin
						fin = 1'b1; state_d = S_IDLE;
					end else begin
						we    = 1'b1;
						wdata = nsz_q[VAL_W-1:0];
						if (idx_q == '0) begin
							fin = 1'b1; state_d = S_IDLE;
						end else begin
							state_d = S_UPSTEP;
						end
					end
				end else if (idx_q == '0) begin
					fin = 1'b1; fin_st = ST_FAIL; state_d = S_IDLE;
				end else begin
					idx_d   = par;
					nsz_d   = nsz_q << 1;
					state_d = S_FRD;
				end
			end
			// update ancestors up to the root, merging free buddies
			S_UPSTEP: begin
				idx_d   = par;
				nsz_d   = nsz_q << 1;
				raddr   = (par << 1) + IDX_W'(1);
				state_d = S_UPL;
			end
			S_UPL: begin
				l_d     = rdata_q;
				raddr   = (idx_q << 1) + IDX_W'(2);
				state_d = S_UPR;
			end
			S_UPR: begin
				we    = 1'b1;
				wdata = (CNT_W'(lr_sum) == nsz_q) ? nsz_q[VAL_W-1:0] : lr_max;
				if (idx_q == '0) begin
					fin = 1'b1; state_d = S_IDLE;
				end else begin
					state_d = S_UPSTEP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin)
			state_d = S_IDLE;
	end

	// result beat contents, taken from this cycle's offset and size
	always_comb begin
		rsp_d.status        = fin_st;
		rsp_d.result_offset = (fin_st == ST_OK) ? off_d : '0;
		rsp_d.size_bytes    = (fin_st == ST_OK) ? size_d : '0;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			nsz_q   <= CNT_W'(2 * NUM_BLOCKS);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			nsz_q   <= nsz_d;
			done_q  <= fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		p_q         <= p_d;
		pbb_q       <= pbb_d;
		blk_q       <= blk_d;
		quo_q       <= quo_d;
		prod_q      <= prod_d;
		rem_q       <= rem_d;
		bit_q       <= bit_d;
		l_q         <= l_d;
		off_q       <= off_d;
		size_q      <= size_d;
		req_bytes_q <= req_bytes_d;
		is_free_q   <= is_free_d;
		if (fin)
			rsp_q <= rsp_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule

[verif/bba_checker.sv]
`timescale 1ns / 100ps

module bba_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  bba_pkg::bba_req_t        req,
	input  logic                     done,
	input  bba_pkg::bba_rsp_t        result,
	input  logic                     cfg_we,
	input  logic [bba_pkg::BB_W-1:0] cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       grants,
	output int                       results_seen
);
	import bba_pkg::*;

	logic [BB_W-1:0]  blk_reg;
	int unsigned      run_tree [NODES];
	bba_rsp_t         due_q [$];

	// restore the tree to its post-reset contents
	function automatic void tree_reset();
		int unsigned nsz;
		nsz = 2 * NUM_BLOCKS;
		for (int i = 0; i < NODES; i++) begin
			if ((((i + 1) & i)) == 0) nsz = nsz >> 1;
			run_tree[i] = nsz;
		end
	endfunction

	function automatic longint unsigned clamp_block();
		longint unsigned b;
		b = blk_reg;
		if (b < 4) b = 4;
		if (b > 65536) b = 65536;
		return b;
	endfunction

	function automatic bba_rsp_t mk(logic [1:0] st, longint unsigned off,
			longint unsigned sz);
		bba_rsp_t r;
		r.status        = st;
		r.result_offset = off[OFF_W-1:0];
		r.size_bytes    = sz[REQ_W-1:0];
		return r;
	endfunction

	function automatic bba_rsp_t predict_alloc(longint unsigned rq);
		longint unsigned bb, want, p, off;
		int unsigned idx, nsz, l, r;
		bb = clamp_block();
		idx = 0;
		nsz = NUM_BLOCKS;
		p = 1;
		if (rq == 0) return mk(ST_BAD, 0, 0);
		want = (rq + bb - 1) / bb;
		while (p < want && p <= NUM_BLOCKS) p = p << 1;
		if (p > NUM_BLOCKS || run_tree[0] < p) return mk(ST_FAIL, 0, 0);
		while (nsz != p) begin
			l = 2 * idx + 1;
			idx = (run_tree[l] >= p) ? l : l + 1;
			nsz = nsz >> 1;
		end
		off = (longint'(idx + 1) * nsz - NUM_BLOCKS) * bb;
		if (off + p * bb > 64'h1000000) return mk(ST_FAIL, 0, 0);
		run_tree[idx] = 0;
		while (idx != 0) begin
			idx = (idx + 1) / 2 - 1;
			l = run_tree[2 * idx + 1];
			r = run_tree[2 * idx + 2];
			run_tree[idx] = (l > r) ? l : r;
		end
		return mk(ST_OK, off, p * bb);
	endfunction

	function automatic bba_rsp_t predict_release(bit is_free, longint unsigned boff);
		longint unsigned bb;
		int unsigned idx, nsz, l, r;
		bit found;
		bb = clamp_block();
		found = 0;
		if (boff >= NUM_BLOCKS * bb) return mk(ST_BAD, 0, 0);
		idx = int'(boff / bb) + NUM_BLOCKS - 1;
		nsz = 1;
		// climb to the first taken node
		forever begin
			if (run_tree[idx] == 0) begin
				found = 1;
				break;
			end
			if (idx == 0) break;
			idx = (idx + 1) / 2 - 1;
			nsz = nsz << 1;
		end
		if (!found) return mk(ST_FAIL, 0, 0);
		predict_release = mk(ST_OK, 0, longint'(nsz) * bb);
		if (!is_free) return predict_release;
		run_tree[idx] = nsz;
		while (idx != 0) begin
			idx = (idx + 1) / 2 - 1;
			nsz = nsz << 1;
			l = run_tree[2 * idx + 1];
			r = run_tree[2 * idx + 2];
			run_tree[idx] = (l + r == nsz) ? nsz : ((l > r) ? l : r);
		end
	endfunction

	assign pending = due_q.size();

	// predict on each accepted beat, compare on each result beat
	always @(posedge clk or negedge arst_n) begin
		bba_rsp_t e;
		if (!arst_n) begin
			blk_reg      <= BB_RESET;
			fail_count   <= 0;
			grants       <= 0;
			results_seen <= 0;
			due_q.delete();
			tree_reset();
		end else begin
			if (done) begin
				results_seen <= results_seen + 1;
				if (due_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %h", result);
					fail_count <= fail_count + 1;
				end else begin
					e = due_q.pop_front();
					if (e !== result) begin
						if (fail_count < 10)
							$display("mismatch: exp st=%0d off=%h sz=%h, got st=%0d off=%h sz=%h",
								e.status, e.result_offset, e.size_bytes,
								result.status, result.result_offset, result.size_bytes);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				case (req.action)
					ACT_ALLOC: e = predict_alloc(req.request_bytes);
					ACT_FREE:  e = predict_release(1, req.byte_offset);
					ACT_QUERY: e = predict_release(0, req.byte_offset);
					default:   e = mk(ST_BAD, 0, 0);
				endcase
				if (req.action == ACT_ALLOC && e.status == ST_OK) grants <= grants + 1;
				due_q.push_back(e);
			end
			if (cfg_we) blk_reg <= cfg_data;
		end
	end
endmodule

[verif/tb_buddy_block_allocator.sv]
`timescale 1ns / 100ps

module tb_buddy_block_allocator;
	import bba_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	bba_req_t        req;
	logic            done;
	bba_rsp_t        result;
	logic            cfg_we;
	logic [BB_W-1:0] cfg_data;
	int              fail_count, pending, grants, results_seen;
	int              idle_pct;
	int              sent;
	int unsigned     quiet;
	longint unsigned cur_bb;
	logic [OFF_W-1:0] held [$];

	buddy_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	bba_checker i_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .grants(grants),
		.results_seen(results_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog on cycles without any accepted or result beat
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one beat and hold it until busy is low; start stays high for the next beat
	task automatic send(logic [1:0] act, logic [REQ_W-1:0] rq, logic [OFF_W-1:0] off);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start             <= 1'b1;
		req.action        <= act;
		req.request_bytes <= rq;
		req.byte_offset   <= off;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic set_block(logic [BB_W-1:0] v);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_bb = (v < 4) ? 4 : (v > 65536) ? 65536 : v;
		held.delete();
	endtask

	// mostly allocate, free and query random offsets, with some noise
	task automatic random_ops(int n);
		int k, pick;
		logic [OFF_W-1:0] o;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 45) begin
				k = $urandom_range(8, 0);
				send(ACT_ALLOC, REQ_W'($urandom_range(int'(cur_bb << k), 1)), '0);
				held.push_back(OFF_W'(0));
			end else if (pick < 75 && held.size() > 0) begin
				o = OFF_W'($urandom_range(int'(cur_bb) * NUM_BLOCKS - 1, 0));
				send(($urandom_range(1, 0)) ? ACT_FREE : ACT_QUERY, REQ_W'($urandom), o);
				void'(held.pop_front());
			end else if (pick < 90) begin
				send(ACT_FREE, REQ_W'($urandom),
					OFF_W'($urandom_range(int'(cur_bb) * NUM_BLOCKS - 1, 0)));
			end else begin
				send(2'($urandom), REQ_W'($urandom), OFF_W'($urandom));
			end
		end
	endtask

	initial begin
		start    <= 1'b0;
		req      <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= BB_RESET;
		arst_n   <= 1'b0;
		idle_pct = 0;
		sent = 0;
		cur_bb = 64;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each action, error paths
		send(ACT_ALLOC, '0, '0);
		send(ACT_ALLOC, 25'h1FFFFFF, '0);
		send(ACT_ALLOC, 25'd16384, '0);
		send(ACT_ALLOC, 25'd1, '0);
		send(ACT_QUERY, '0, '0);
		send(ACT_FREE, '0, 24'd16384);
		send(ACT_FREE, '0, '0);
		send(ACT_ALLOC, 25'd65, '0);
		send(ACT_QUERY, '0, 24'd3);
		send(ACT_QUERY, '0, 24'd16383);
		send(ACT_FREE, '0, 24'hFFFFFF);
		send(ACT_FREE, '0, 24'd10000);
		send(2'd3, 25'h1FFFFFF, 24'hFFFFFF);
		send(ACT_ALLOC, 25'd8192, '0);
		send(ACT_ALLOC, 25'd8192, '0);
		send(ACT_ALLOC, 25'd1, '0);
		send(ACT_FREE, '0, 24'd8192);
		send(ACT_FREE, '0, '0);
		set_block(17'h1FFFF);
		send(ACT_ALLOC, 25'h1000000, '0);
		send(ACT_ALLOC, 25'd65536, '0);
		set_block(17'd0);
		send(ACT_ALLOC, 25'd1, '0);
		send(ACT_QUERY, '0, 24'd1023);

		// random phases across idling levels and block sizes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 75;
				2: idle_pct = 10;
				default: idle_pct = 0;
			endcase
			case (ph)
				0: set_block(17'd64);
				1: set_block(17'd4);
				2: set_block(17'd65536);
				3: set_block(17'd100);
				4: set_block(17'd3);
				5: set_block(17'h10000 | 17'($urandom_range(65535, 0)));
				6: set_block(17'($urandom_range(4096, 5)));
				default: set_block(17'd64);
			endcase
			random_ops(100);
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d operations over 8 block sizes; %0d results, %0d grants.",
			sent, results_seen, grants);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

[files.f]
sv/bba_pkg.sv
sv/buddy_block_allocator.sv
verif/bba_checker.sv
verif/tb_buddy_block_allocator.sv
